[hw/rtl/vtdt_pkg.sv]
`default_nettype none

package vtdt_pkg;

  // Defaults for the top level parameters
  localparam int unsigned TABLE_DEPTH_DEF = 4096;
  localparam int unsigned INDEX_BITS_DEF  = 24;

  // Result vertex index width (reported modulo 2**VERTEX_W)
  localparam int unsigned VERTEX_W = 11;

  // Key bytes hashed per triplet: three 32-bit little-endian words
  localparam int unsigned KEY_BYTES = 12;

  // 64-bit FNV-1a constants; the hash unit uses only the low table-index bits
  localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
  localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_EMIT
  } vtdt_state_e;

endpackage

`default_nettype wire

[hw/rtl/vtdt_ram.sv]
`default_nettype none

module vtdt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/vtdt_hash.sv]
`default_nettype none

module vtdt_hash
  import vtdt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned INDEX_BITS  = INDEX_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [INDEX_BITS-1:0]          pos_i,
  input  wire logic [INDEX_BITS-1:0]          tex_i,
  input  wire logic [INDEX_BITS-1:0]          nrm_i,
  output logic                                done_o,
  output logic      [$clog2(TABLE_DEPTH)-1:0] hash_o
);

  localparam int unsigned HW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(KEY_BYTES);
  localparam logic [HW-1:0] BASIS_LO = FNV_BASIS[HW-1:0];
  localparam logic [HW-1:0] PRIME_LO = FNV_PRIME[HW-1:0];

  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [HW-1:0]           h_q, h_d;
  logic [INDEX_BITS+31:0]  word_wide;
  logic [31:0]             word;
  logic [31:0]             word_sh;
  logic [7:0]              key_byte;
  logic [HW+7:0]           mix_wide;
  logic [HW-1:0]           mix;
  logic [2*HW-1:0]         prod;

  // Byte cnt: word cnt[3:2], byte lane cnt[1:0] (little-endian)
  always_comb begin
    unique case (cnt_q[CNT_W-1:2])
      2'd0:    word_wide = {32'b0, pos_i};
      2'd1:    word_wide = {32'b0, tex_i};
      2'd2:    word_wide = {32'b0, nrm_i};
      default: word_wide = '0;
    endcase
  end

  assign word     = word_wide[31:0];
  assign word_sh  = word >> {cnt_q[1:0], 3'b000};
  assign key_byte = word_sh[7:0];
  assign mix_wide = {8'b0, h_q} ^ {{HW{1'b0}}, key_byte};
  assign mix      = mix_wide[HW-1:0];
  assign prod     = mix * PRIME_LO;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    h_d    = h_q;
    if (start_i) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      h_d    = BASIS_LO;
    end else if (busy_q) begin
      h_d   = prod[HW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(KEY_BYTES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
  end

  assign done_o = done_q;
  assign hash_o = h_q;

endmodule

`default_nettype wire

[hw/rtl/vertex_triplet_dedup_table_top.sv]
`default_nettype none

// Channel | Direction | Handshake                   | Payload
// --------+-----------+-----------------------------+---------------------------------------
// in      | input     | in_valid_i / in_stall_o     | position_index_i, texcoord_index_i,
//         |           |                             | normal_index_i
// out     | output    | out_valid_o / out_stall_i   | vertex_index_o, is_new_o, table_full_o
//
// Flow: an input transaction is hashed over its 12 key bytes, one byte per step, by
//   the FNV-1a unit; the home slot is read, slots are compared one per probe step,
//   and the result is emitted. The next input is taken only once the result has
//   left the emit state. The byte-serial hash multiplier and the single table read
//   port set the throughput.
// Reset: a clearing pass writes every table slot empty, with in_stall_o held
//   high; the item count restarts at zero.
// Stalls: a finished result sits in the output register while the next input
//   transaction is taken; a result waits in the emit state only if that register
//   is still full and stalled.

module vertex_triplet_dedup_table_top
  import vtdt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned INDEX_BITS  = INDEX_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [INDEX_BITS-1:0] position_index_i,
  input  wire logic [INDEX_BITS-1:0] texcoord_index_i,
  input  wire logic [INDEX_BITS-1:0] normal_index_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [VERTEX_W-1:0]   vertex_index_o,
  output logic                       is_new_o,
  output logic                       table_full_o
);

  localparam int unsigned HW   = $clog2(TABLE_DEPTH);
  localparam int unsigned KW   = 3 * INDEX_BITS;
  localparam int unsigned RW   = 1 + KW + VERTEX_W;
  localparam int unsigned HALF = TABLE_DEPTH / 2;

  vtdt_state_e state_q, state_d;

  // Table word: {occupied, key triplet, vertex index}
  logic              ram_we;
  logic [HW-1:0]     ram_waddr;
  logic [RW-1:0]     ram_wdata;
  logic [HW-1:0]     ram_raddr;
  logic [RW-1:0]     ram_rdata;

  logic              rd_valid;
  logic [KW-1:0]     rd_key;
  logic [VERTEX_W-1:0] rd_vtx;

  logic [HW-1:0]     clr_q;
  logic [HW-1:0]     count_q;
  logic [HW-1:0]     cmp_slot_q;
  logic [KW-1:0]     key_q;

  logic [VERTEX_W-1:0] res_vtx_q;
  logic              res_new_q;
  logic              res_full_q;

  logic              out_valid_q;
  logic [VERTEX_W-1:0] out_vtx_q;
  logic              out_new_q;
  logic              out_full_q;

  logic              hash_done;
  logic [HW-1:0]     hash;

  logic [VERTEX_W+HW-1:0] count_wide;
  logic [VERTEX_W-1:0]    count_vtx;
  logic              full;
  logic              hit;
  logic              accept;
  logic              probe_done;
  logic              insert;
  logic              load_out;
  logic              clr_last;

  assign accept = in_valid_i && !in_stall_o;

  vtdt_hash #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_BITS  (INDEX_BITS)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .pos_i   (key_q[2*INDEX_BITS +: INDEX_BITS]),
    .tex_i   (key_q[INDEX_BITS +: INDEX_BITS]),
    .nrm_i   (key_q[0 +: INDEX_BITS]),
    .done_o  (hash_done),
    .hash_o  (hash)
  );

  vtdt_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_valid = ram_rdata[RW-1];
  assign rd_key   = ram_rdata[VERTEX_W +: KW];
  assign rd_vtx   = ram_rdata[VERTEX_W-1:0];

  // Running count doubles as the next vertex index, reported modulo 2**VERTEX_W
  assign count_wide = {{VERTEX_W{1'b0}}, count_q};
  assign count_vtx  = count_wide[VERTEX_W-1:0];
  assign full       = (count_q >= HW'(HALF));
  assign hit        = rd_valid && (rd_key == key_q);
  assign clr_last   = (clr_q == {HW{1'b1}});

  // State outputs. In the probe state the slot under compare is cmp_slot_q and
  // the read for the following slot goes out in the same cycle, so a probe
  // chain runs one slot per cycle.
  always_comb begin
    in_stall_o = 1'b1;
    ram_we     = 1'b0;
    ram_waddr  = cmp_slot_q;
    ram_wdata  = {1'b1, key_q, count_vtx};
    ram_raddr  = cmp_slot_q + 1'b1;
    probe_done = 1'b0;
    insert     = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_HASH: begin
        ram_raddr = hash;
      end
      ST_PROBE: begin
        probe_done = hit || !rd_valid;
        insert     = !rd_valid && !full;
        ram_we     = insert;
      end
      ST_EMIT: begin
        load_out = !out_valid_q || !out_stall_i;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_last)   state_d = ST_IDLE;
      ST_IDLE:  if (accept)     state_d = ST_HASH;
      ST_HASH:  if (hash_done)  state_d = ST_PROBE;
      ST_PROBE: if (probe_done) state_d = ST_EMIT;
      ST_EMIT:  if (load_out)   state_d = ST_IDLE;
      default:                  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (insert) begin
        count_q <= count_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= {position_index_i, texcoord_index_i, normal_index_i};
    end
    if (state_q == ST_HASH && hash_done) begin
      cmp_slot_q <= hash;
    end else if (state_q == ST_PROBE && !probe_done) begin
      cmp_slot_q <= cmp_slot_q + 1'b1;  // linear probe, wraps with the index width
    end
    if (probe_done) begin
      priority if (hit) begin
        res_vtx_q  <= rd_vtx;
        res_new_q  <= 1'b0;
        res_full_q <= 1'b0;
      end else if (insert) begin
        res_vtx_q  <= count_vtx;
        res_new_q  <= 1'b1;
        res_full_q <= 1'b0;
      end else begin
        // new triplet while half full: dropped, state untouched
        res_vtx_q  <= '0;
        res_new_q  <= 1'b0;
        res_full_q <= 1'b1;
      end
    end
    if (load_out) begin
      out_vtx_q  <= res_vtx_q;
      out_new_q  <= res_new_q;
      out_full_q <= res_full_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign vertex_index_o = out_vtx_q;
  assign is_new_o       = out_new_q;
  assign table_full_o   = out_full_q;

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

// Vertex triplet dedup table: lookups are checked against a behavioral copy
// of the FNV-1a hashed, linearly probed table. Every accepted input
// transaction is pushed through the local table right away. The expected
// result is queued, and the output monitor compares each result against the
// oldest one in the queue.

module testbench;
  import vtdt_pkg::*;

  localparam int unsigned DEPTH  = TABLE_DEPTH_DEF;
  localparam int unsigned IDX_W  = INDEX_BITS_DEF;
  localparam int unsigned HALF   = DEPTH / 2;
  localparam int unsigned SLOT_W = $clog2(DEPTH);

  typedef logic [IDX_W-1:0]   index_t;
  typedef logic [3*IDX_W-1:0] triplet_t;  // {position, texcoord, normal}

  localparam index_t IDX_MAX = '1;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex_index;
    logic                is_new;
    logic                table_full;
  } corner_result_t;

  // DUT pins; every input has a known value from time zero
  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               in_valid_i       = 1'b0;
  logic               in_stall_o;
  index_t             position_index_i = '0;
  index_t             texcoord_index_i = '0;
  index_t             normal_index_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i      = 1'b0;
  logic [VERTEX_W-1:0] vertex_index_o;
  logic               is_new_o;
  logic               table_full_o;

  // Local copy of the table
  bit          slot_used    [DEPTH];
  triplet_t    slot_triplet [DEPTH];
  int unsigned slot_vertex  [DEPTH];
  int unsigned entry_count;
  triplet_t    known_q[$];  // triplets inserted so far, in vertex order

  corner_result_t result_q[$];  // results still owed by the block

  // Traffic shaping, percent of cycles
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned err_cnt;

  vertex_triplet_dedup_table_top #(
    .TABLE_DEPTH(DEPTH),
    .INDEX_BITS (IDX_W)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .position_index_i(position_index_i),
    .texcoord_index_i(texcoord_index_i),
    .normal_index_i  (normal_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .vertex_index_o  (vertex_index_o),
    .is_new_o        (is_new_o),
    .table_full_o    (table_full_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Hash and table lookup
  // ---------------------------------------------------------------------------

  // FNV-1a over three 32-bit little-endian words, masked to the table depth
  function automatic logic [SLOT_W-1:0] home_slot(triplet_t t);
    logic [63:0] h;
    logic [31:0] w;
    int          f;
    int          b;
    h = FNV_BASIS;
    for (f = 0; f < 3; f++) begin
      w = 32'(t[(2 - f) * IDX_W +: IDX_W]);
      for (b = 0; b < 4; b++) begin
        h = h ^ 64'(w[8 * b +: 8]);
        h = h * FNV_PRIME;
      end
    end
    return h[SLOT_W-1:0];
  endfunction

  // Looks up one corner and inserts it when new; updates the local table
  function automatic corner_result_t dedup_lookup(triplet_t t);
    corner_result_t r;
    int unsigned    s;
    int unsigned    probes;
    bit             hit;
    r      = '0;
    s      = 32'(home_slot(t));
    probes = 0;
    hit    = 1'b0;
    while (probes < DEPTH && slot_used[s] && !hit) begin
      if (slot_triplet[s] == t) begin
        hit = 1'b1;
      end else begin
        s = (s + 1) % DEPTH;
        probes++;
      end
    end
    if (hit) begin
      r.vertex_index = VERTEX_W'(slot_vertex[s]);
    end else if (entry_count >= HALF || probes >= DEPTH) begin
      // dropped: nothing stored, vertex index reads zero
      r.table_full = 1'b1;
    end else begin
      slot_used[s]    = 1'b1;
      slot_triplet[s] = t;
      slot_vertex[s]  = entry_count;
      r.vertex_index  = VERTEX_W'(entry_count);
      r.is_new        = 1'b1;
      entry_count++;
      known_q.push_back(t);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic triplet_t random_triplet();
    return {index_t'($urandom), index_t'($urandom), index_t'($urandom)};
  endfunction

  // Random triplet whose probe starts at the given slot
  function automatic triplet_t key_at_slot(logic [SLOT_W-1:0] target);
    triplet_t t;
    do begin
      t = random_triplet();
    end while (home_slot(t) != target);
    return t;
  endfunction

  // Mesh-like mix: repeats of known corners, small indices, near misses,
  // extreme field values and fully random triplets
  function automatic triplet_t pick_corner();
    triplet_t    t;
    int unsigned k;
    int unsigned f;
    k = $urandom_range(99);
    if (k < 40 && known_q.size() != 0) begin
      t = known_q[$urandom_range(known_q.size() - 1)];
    end else if (k < 65) begin
      t = {index_t'($urandom_range(1, 48)), index_t'($urandom_range(1, 48)),
           index_t'($urandom_range(1, 48))};
    end else if (k < 75 && known_q.size() != 0) begin
      // one field off from a stored corner
      t = known_q[$urandom_range(known_q.size() - 1)];
      t[$urandom_range(2) * IDX_W +: IDX_W] = index_t'($urandom);
    end else if (k < 82) begin
      t = random_triplet();
      for (f = 0; f < 3; f++) begin
        case ($urandom_range(2))
          0: begin
            t[f * IDX_W +: IDX_W] = '0;
          end
          1: begin
            t[f * IDX_W +: IDX_W] = IDX_MAX;
          end
          default: begin
          end
        endcase
      end
    end else begin
      t = random_triplet();
    end
    return t;
  endfunction

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Offers one transaction; entered and left at a falling edge with valid
  // still high so back-to-back transactions need no gap
  task automatic send_corner(triplet_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    {position_index_i, texcoord_index_i, normal_index_i} <= t;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    result_q.push_back(dedup_lookup(t));
    @(negedge clk_i);
  endtask

  // Sender pauses until every owed result has been seen
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do begin
      @(negedge clk_i);
    end while (result_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_corners();
    triplet_t wrap_a;
    triplet_t wrap_b;
    triplet_t chain_a;
    set_idling(0, 0);
    send_corner('0);  // first insert gets vertex 0
    send_corner('0);
    send_corner('1);
    send_corner('1);
    send_corner({IDX_MAX, index_t'(0), index_t'(0)});
    send_corner({index_t'(0), IDX_MAX, index_t'(0)});
    send_corner({index_t'(0), index_t'(0), IDX_MAX});
    send_corner({index_t'(1), index_t'(1), index_t'(1)});
    send_corner({index_t'(1), index_t'(2), index_t'(3)});
    send_corner({index_t'(3), index_t'(2), index_t'(1)});
    // both start at the last slot, so the second one wraps to slot zero
    wrap_a = key_at_slot('1);
    wrap_b = key_at_slot('1);
    send_corner(wrap_a);
    send_corner(wrap_b);
    send_corner(wrap_b);
    send_corner(wrap_a);
    // collides with (1,1,1) and sits one slot further down the chain
    chain_a = key_at_slot(home_slot({index_t'(1), index_t'(1), index_t'(1)}));
    send_corner(chain_a);
    send_corner(chain_a);
    send_corner({index_t'(1), index_t'(1), index_t'(1)});
    wait_drained();
  endtask

  task automatic test_random_lookups();
    int unsigned phase_send[4] = '{0, 54, 0, 18};
    int unsigned phase_recv[4] = '{0, 0, 54, 18};
    int          p;
    int          i;
    for (p = 0; p < 4; p++) begin
      set_idling(phase_send[p], phase_recv[p]);
      for (i = 0; i < 200; i++) begin
        send_corner(pick_corner());
      end
      wait_drained();
    end
  endtask

  // Receiver holds off while the sender keeps going, so the block backs up
  // into its input
  task automatic test_output_holdoff();
    int i;
    set_idling(0, 0);
    hold_req = 1'b1;
    for (i = 0; i < 30; i++) begin
      send_corner(pick_corner());
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall plus an optional long hold-off counted here
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: one check per accepted result transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    corner_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        $error("result with none owed: vertex_index %0d is_new %0b table_full %0b",
               vertex_index_o, is_new_o, table_full_o);
        err_cnt++;
      end else begin
        want = result_q.pop_front();
        if (vertex_index_o !== want.vertex_index) begin
          $error("vertex_index: expected %0d, got %0d", want.vertex_index,
                 vertex_index_o);
          err_cnt++;
        end
        if (is_new_o !== want.is_new) begin
          $error("is_new: expected %0b, got %0b", want.is_new, is_new_o);
          err_cnt++;
        end
        if (table_full_o !== want.table_full) begin
          $error("table_full: expected %0b, got %0b", want.table_full, table_full_o);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence; the block runs its clearing pass after reset with input stalled
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_corners();
    test_random_lookups();
    test_output_holdoff();
    // quiet tail to catch any stray result
    repeat (100) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run
  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/vtdt_pkg.sv
hw/rtl/vtdt_ram.sv
hw/rtl/vtdt_hash.sv
hw/rtl/vertex_triplet_dedup_table_top.sv
test/testbench.sv
